[design/lfp_pkg.sv]
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared widths, constants, register indexes and per-item flag structs for the
// line-follow PID datapath.
// ----------------------------------------------------------------------------
package lfp_pkg;

  // field widths of the stream items
  localparam int FIELD_W     = 10;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int DRIVE_W     = 11;
  localparam int CNT_W       = 16;

  // configuration widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PGAIN_W    = 16;
  localparam int GAIN_W     = 32;
  localparam int THR_W      = 10;
  localparam int BASE_W     = 8;

  // accumulator and control scaling
  localparam int SUM_W       = 32;
  localparam int ACC_W       = 64;
  localparam int ALIGN_SHIFT = 16;
  localparam int CTRL_SHIFT  = 24;
  localparam int CTRL_W      = ACC_W - CTRL_SHIFT;

  // error scale 254/775 as multiply by a rounded-up reciprocal, exact for
  // differences below 2^12
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] ERR_RECIP = 29'd351910396;

  // saturation limits
  localparam logic signed [DRIVE_W-1:0] DRIVE_HI = 11'sd1023;
  localparam logic signed [DRIVE_W-1:0] DRIVE_LO = -11'sd1023;
  localparam logic signed [SUM_W-1:0]   SUM_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [SUM_W-1:0]   SUM_MIN  = 32'sh8000_0000;
  localparam logic [CNT_W-1:0]          CNT_MAX  = 16'hFFFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_GAIN         = 3'd0,
    REG_I_GAIN_DT      = 3'd1,
    REG_D_GAIN_PER_DT  = 3'd2,
    REG_LINE_THRESHOLD = 3'd3,
    REG_BASE_SPEED     = 3'd4
  } cfg_reg_t;

  // per-item flags out of the front stage
  typedef struct packed {
    logic on_line;
    logic clear_count;
    logic clear_errors;
  } front_flags_t;

  // line status carried to the result
  typedef struct packed {
    logic on_line;
    logic line_edge;
  } line_stat_t;

endpackage

[design/lfp_front.sv]
// ----------------------------------------------------------------------------
// lfp_front
// Input register, then line detect and scaled sensor error into a second
// register stage.
// ----------------------------------------------------------------------------
module lfp_front
  import lfp_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [FIELD_W-1:0]            right_sample,
  input  logic [FIELD_W-1:0]            left_sample,
  input  logic                          clear_count,
  input  logic                          clear_errors,
  input  logic [THR_W-1:0]              line_threshold,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] err,
  output front_flags_t                  flags
);

  localparam int WIDE_W = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;
  localparam int PROD_W = SAMPLE_BITS + RECIP_W;
  localparam int QUOT_W = PROD_W - RECIP_SHIFT;

  logic                          a_v_r;
  logic [FIELD_W-1:0]            a_right_r;
  logic [FIELD_W-1:0]            a_left_r;
  logic                          a_clr_cnt_r;
  logic                          a_clr_err_r;
  logic                          b_v_r;
  logic signed [SAMPLE_BITS-1:0] b_err_r;
  front_flags_t                  b_flags_r;

  logic                          b_ready;
  logic [WIDE_W-1:0]             right_wide;
  logic [WIDE_W-1:0]             left_wide;
  logic [SAMPLE_BITS-1:0]        rs;
  logic [SAMPLE_BITS-1:0]        ls;
  logic                          on_nxt;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [PROD_W-1:0]             prod;
  logic [QUOT_W-1:0]             quot;
  logic signed [SAMPLE_BITS-1:0] err_nxt;
  front_flags_t                  flags_nxt;

  // stage handshakes
  assign in_ready = !a_v_r || b_ready;
  assign b_ready  = !b_v_r || out_ready;

  // samples cut to the converter width
  assign right_wide = WIDE_W'(a_right_r);
  assign left_wide  = WIDE_W'(a_left_r);
  assign rs         = right_wide[SAMPLE_BITS-1:0];
  assign ls         = left_wide[SAMPLE_BITS-1:0];

  // both sensors on dark line
  assign on_nxt = (WIDE_W'(rs) >= WIDE_W'(line_threshold)) &&
                  (WIDE_W'(ls) >= WIDE_W'(line_threshold));

  // error = (left - right) * 254 / 775, toward zero, on the magnitude
  assign diff    = $signed({1'b0, ls}) - $signed({1'b0, rs});
  assign mag     = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
  assign prod    = PROD_W'(mag) * ERR_RECIP;
  assign quot    = prod[PROD_W-1:RECIP_SHIFT];
  assign err_nxt = diff[SAMPLE_BITS] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  assign flags_nxt.on_line      = on_nxt;
  assign flags_nxt.clear_count  = a_clr_cnt_r;
  assign flags_nxt.clear_errors = a_clr_err_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (in_ready) a_v_r <= in_valid;
      if (b_ready)  b_v_r <= a_v_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_right_r   <= right_sample;
      a_left_r    <= left_sample;
      a_clr_cnt_r <= clear_count;
      a_clr_err_r <= clear_errors;
    end
    if (a_v_r && b_ready) begin
      b_err_r   <= err_nxt;
      b_flags_r <= flags_nxt;
    end
  end

  assign out_valid = b_v_r;
  assign err       = b_err_r;
  assign flags     = b_flags_r;

endmodule

[design/lfp_track.sv]
// ----------------------------------------------------------------------------
// lfp_track
// Holds the loop state: previous error, saturating error sum, line flag
// history and crossing count. Updates once per item in order.
// ----------------------------------------------------------------------------
module lfp_track
  import lfp_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] err_i,
  input  front_flags_t                  flags_i,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] err_o,
  output logic signed [SAMPLE_BITS:0]   delta_o,
  output logic signed [SUM_W-1:0]       sum_o,
  output logic [CNT_W-1:0]              crossings_o,
  output line_stat_t                    stat_o
);

  logic signed [SAMPLE_BITS-1:0] last_err_r;
  logic signed [SUM_W-1:0]       err_sum_r;
  logic                          was_on_r;
  logic [CNT_W-1:0]              count_r;

  logic                          c_v_r;
  logic signed [SAMPLE_BITS-1:0] c_err_r;
  logic signed [SAMPLE_BITS:0]   c_delta_r;
  logic signed [SUM_W-1:0]       c_sum_r;
  logic [CNT_W-1:0]              c_cnt_r;
  line_stat_t                    c_stat_r;

  logic                          step;
  logic signed [SAMPLE_BITS-1:0] last_eff;
  logic signed [SUM_W-1:0]       sum_eff;
  logic [CNT_W-1:0]              cnt_eff;
  logic                          edge_nxt;
  logic [CNT_W-1:0]              cnt_nxt;
  logic signed [SAMPLE_BITS:0]   delta_nxt;
  logic signed [SUM_W:0]         sum_add;
  logic signed [SUM_W-1:0]       sum_nxt;
  line_stat_t                    stat_nxt;

  assign in_ready = !c_v_r || out_ready;
  assign step     = in_valid && in_ready;

  // clears act before this item
  assign last_eff = flags_i.clear_errors ? '0 : last_err_r;
  assign sum_eff  = flags_i.clear_errors ? '0 : err_sum_r;
  assign cnt_eff  = flags_i.clear_count  ? '0 : count_r;

  // rising edge of the line flag, saturating count
  assign edge_nxt = flags_i.on_line && !was_on_r;
  assign cnt_nxt  = (edge_nxt && (cnt_eff != CNT_MAX)) ? cnt_eff + 1'b1 : cnt_eff;

  // error change
  assign delta_nxt = {err_i[SAMPLE_BITS-1], err_i} - {last_eff[SAMPLE_BITS-1], last_eff};

  // saturating error sum
  assign sum_add = {sum_eff[SUM_W-1], sum_eff} +
                   {{(SUM_W+1-SAMPLE_BITS){err_i[SAMPLE_BITS-1]}}, err_i};
  always_comb begin
    if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
      sum_nxt = sum_add[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_add[SUM_W-1:0];
    end
  end

  assign stat_nxt.on_line   = flags_i.on_line;
  assign stat_nxt.line_edge = edge_nxt;

  // loop state and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      err_sum_r  <= '0;
      was_on_r   <= 1'b0;
      count_r    <= '0;
      c_v_r      <= 1'b0;
    end else begin
      if (in_ready) c_v_r <= in_valid;
      if (step) begin
        last_err_r <= err_i;
        err_sum_r  <= sum_nxt;
        was_on_r   <= flags_i.on_line;
        count_r    <= cnt_nxt;
      end
    end
  end

  // stage payload, sum taken before this item's error
  always_ff @(posedge clk) begin
    if (step) begin
      c_err_r   <= err_i;
      c_delta_r <= delta_nxt;
      c_sum_r   <= sum_eff;
      c_cnt_r   <= cnt_nxt;
      c_stat_r  <= stat_nxt;
    end
  end

  assign out_valid   = c_v_r;
  assign err_o       = c_err_r;
  assign delta_o     = c_delta_r;
  assign sum_o       = c_sum_r;
  assign crossings_o = c_cnt_r;
  assign stat_o      = c_stat_r;

endmodule

[design/lfp_mult.sv]
// ----------------------------------------------------------------------------
// lfp_mult
// The three gain products of the PID term, one registered stage.
// ----------------------------------------------------------------------------
module lfp_mult
  import lfp_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       err_i,
  input  logic signed [SAMPLE_BITS:0]         delta_i,
  input  logic signed [SUM_W-1:0]             sum_i,
  input  logic [CNT_W-1:0]                    crossings_i,
  input  line_stat_t                          stat_i,
  input  logic signed [PGAIN_W-1:0]           p_gain,
  input  logic signed [GAIN_W-1:0]            i_gain_dt,
  input  logic signed [GAIN_W-1:0]            d_gain_per_dt,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS+PGAIN_W-1:0] prod_p,
  output logic signed [SAMPLE_BITS+GAIN_W:0]  prod_d,
  output logic signed [ACC_W-1:0]             prod_i,
  output logic [CNT_W-1:0]                    crossings_o,
  output line_stat_t                          stat_o
);

  logic                                  d_v_r;
  logic signed [SAMPLE_BITS+PGAIN_W-1:0] d_p_r;
  logic signed [SAMPLE_BITS+GAIN_W:0]    d_d_r;
  logic signed [ACC_W-1:0]               d_i_r;
  logic [CNT_W-1:0]                      d_cnt_r;
  line_stat_t                            d_stat_r;

  logic signed [SAMPLE_BITS+PGAIN_W-1:0] p_nxt;
  logic signed [SAMPLE_BITS+GAIN_W:0]    d_nxt;
  logic signed [ACC_W-1:0]               i_nxt;

  assign in_ready = !d_v_r || out_ready;

  // proportional, integral and derivative products
  assign p_nxt = p_gain * err_i;
  assign d_nxt = d_gain_per_dt * delta_i;
  assign i_nxt = i_gain_dt * sum_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (in_ready) begin
      d_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      d_p_r    <= p_nxt;
      d_d_r    <= d_nxt;
      d_i_r    <= i_nxt;
      d_cnt_r  <= crossings_i;
      d_stat_r <= stat_i;
    end
  end

  assign out_valid   = d_v_r;
  assign prod_p      = d_p_r;
  assign prod_d      = d_d_r;
  assign prod_i      = d_i_r;
  assign crossings_o = d_cnt_r;
  assign stat_o      = d_stat_r;

endmodule

[design/lfp_drive.sv]
// ----------------------------------------------------------------------------
// lfp_drive
// Sums the PID products, scales to the control value toward zero and forms
// the saturated wheel commands in the result register.
// ----------------------------------------------------------------------------
module lfp_drive
  import lfp_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS+PGAIN_W-1:0] prod_p,
  input  logic signed [SAMPLE_BITS+GAIN_W:0]    prod_d,
  input  logic signed [ACC_W-1:0]               prod_i,
  input  logic [CNT_W-1:0]                      crossings_i,
  input  line_stat_t                            stat_i,
  input  logic [BASE_W-1:0]                     base_speed,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [DRIVE_W-1:0]             right_drive,
  output logic signed [DRIVE_W-1:0]             left_drive,
  output logic [CNT_W-1:0]                      crossings_o,
  output line_stat_t                            stat_o
);

  localparam int P_W = SAMPLE_BITS + PGAIN_W;
  localparam int D_W = SAMPLE_BITS + GAIN_W + 1;

  logic                       e_v_r;
  logic signed [ACC_W-1:0]    e_acc_r;
  logic [CNT_W-1:0]           e_cnt_r;
  line_stat_t                 e_stat_r;
  logic                       f_v_r;
  logic signed [DRIVE_W-1:0]  f_right_r;
  logic signed [DRIVE_W-1:0]  f_left_r;
  logic [CNT_W-1:0]           f_cnt_r;
  line_stat_t                 f_stat_r;

  logic                       f_ready;
  logic signed [ACC_W-1:0]    p_ext;
  logic signed [ACC_W-1:0]    d_ext;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [CTRL_W-1:0]   ctrl_floor;
  logic                       ctrl_round;
  logic signed [CTRL_W-1:0]   ctrl;
  logic signed [CTRL_W:0]     ctrl_ext;
  logic signed [CTRL_W:0]     base_ext;
  logic signed [CTRL_W:0]     right_sum;
  logic signed [CTRL_W:0]     left_sum;

  // clamp to the drive range
  function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [CTRL_W:0] v);
    logic signed [DRIVE_W-1:0] r;
    if (v > (CTRL_W+1)'(DRIVE_HI)) begin
      r = DRIVE_HI;
    end else if (v < (CTRL_W+1)'(DRIVE_LO)) begin
      r = DRIVE_LO;
    end else begin
      r = v[DRIVE_W-1:0];
    end
    return r;
  endfunction

  assign in_ready = !e_v_r || f_ready;
  assign f_ready  = !f_v_r || out_ready;

  // aligned sum of the three terms
  assign p_ext   = {{(ACC_W-P_W){prod_p[P_W-1]}}, prod_p};
  assign d_ext   = {{(ACC_W-D_W){prod_d[D_W-1]}}, prod_d};
  assign acc_nxt = ((p_ext + d_ext) <<< ALIGN_SHIFT) + prod_i;

  // divide by 2^24 toward zero
  assign ctrl_floor = e_acc_r[ACC_W-1:CTRL_SHIFT];
  assign ctrl_round = e_acc_r[ACC_W-1] && (e_acc_r[CTRL_SHIFT-1:0] != '0);
  assign ctrl       = ctrl_floor + $signed({{(CTRL_W-1){1'b0}}, ctrl_round});

  // base plus and minus control
  assign ctrl_ext  = {ctrl[CTRL_W-1], ctrl};
  assign base_ext  = $signed({{(CTRL_W+1-BASE_W){1'b0}}, base_speed});
  assign right_sum = base_ext + ctrl_ext;
  assign left_sum  = base_ext - ctrl_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else begin
      if (in_ready) e_v_r <= in_valid;
      if (f_ready)  f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      e_acc_r  <= acc_nxt;
      e_cnt_r  <= crossings_i;
      e_stat_r <= stat_i;
    end
    if (e_v_r && f_ready) begin
      f_right_r <= sat_drive(right_sum);
      f_left_r  <= sat_drive(left_sum);
      f_cnt_r   <= e_cnt_r;
      f_stat_r  <= e_stat_r;
    end
  end

  assign out_valid   = f_v_r;
  assign right_drive = f_right_r;
  assign left_drive  = f_left_r;
  assign crossings_o = f_cnt_r;
  assign stat_o      = f_stat_r;

endmodule

[design/line_follow_pid_with_stopline_count.sv]
// ----------------------------------------------------------------------------
// line_follow_pid_with_stopline_count
// Line follower PID step with crossing-line counter, streaming in and out.
// ----------------------------------------------------------------------------
// One item per clock while out_tready is high: each sensor pair flows through six
// register stages (input, error scale, loop state, gain products, control sum,
// result), in that order. The loop state (previous error, error sum, line flag,
// crossing count) lives in one stage and is updated once per item, which is
// what lets items follow back to back. Each stage holds its item until the next
// one frees up, so bubbles are squeezed out under backpressure. Configuration
// registers are to be written only while no item is in flight.
module line_follow_pid_with_stopline_count
  import lfp_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // right_sample[9:0], left_sample[19:10], clear_count[20], clear_errors[21]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // right_drive[10:0], left_drive[21:11], on_line[22], line_edge[23],
  // crossings[39:24]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic signed [PGAIN_W-1:0] p_gain_r;
  logic signed [GAIN_W-1:0]  i_gain_dt_r;
  logic signed [GAIN_W-1:0]  d_gain_per_dt_r;
  logic [THR_W-1:0]          line_threshold_r;
  logic [BASE_W-1:0]         base_speed_r;

  logic                                  fr_valid, fr_ready;
  logic signed [SAMPLE_BITS-1:0]         fr_err;
  front_flags_t                          fr_flags;
  logic                                  tr_valid, tr_ready;
  logic signed [SAMPLE_BITS-1:0]         tr_err;
  logic signed [SAMPLE_BITS:0]           tr_delta;
  logic signed [SUM_W-1:0]               tr_sum;
  logic [CNT_W-1:0]                      tr_cnt;
  line_stat_t                            tr_stat;
  logic                                  mu_valid, mu_ready;
  logic signed [SAMPLE_BITS+PGAIN_W-1:0] mu_p;
  logic signed [SAMPLE_BITS+GAIN_W:0]    mu_d;
  logic signed [ACC_W-1:0]               mu_i;
  logic [CNT_W-1:0]                      mu_cnt;
  line_stat_t                            mu_stat;
  logic signed [DRIVE_W-1:0]             right_drive;
  logic signed [DRIVE_W-1:0]             left_drive;
  logic [CNT_W-1:0]                      crossings;
  line_stat_t                            out_stat;
  logic signed [DRIVE_W:0]               drive_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r         <= 16'sd320;
      i_gain_dt_r      <= '0;
      d_gain_per_dt_r  <= '0;
      line_threshold_r <= 10'd600;
      base_speed_r     <= 8'd200;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_P_GAIN:         p_gain_r         <= cfg_wdata[PGAIN_W-1:0];
        REG_I_GAIN_DT:      i_gain_dt_r      <= cfg_wdata[GAIN_W-1:0];
        REG_D_GAIN_PER_DT:  d_gain_per_dt_r  <= cfg_wdata[GAIN_W-1:0];
        REG_LINE_THRESHOLD: line_threshold_r <= cfg_wdata[THR_W-1:0];
        REG_BASE_SPEED:     base_speed_r     <= cfg_wdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register and error scale
  lfp_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .right_sample   (in_tdata[9:0]),
    .left_sample    (in_tdata[19:10]),
    .clear_count    (in_tdata[20]),
    .clear_errors   (in_tdata[21]),
    .line_threshold (line_threshold_r),
    .out_valid      (fr_valid),
    .out_ready      (fr_ready),
    .err            (fr_err),
    .flags          (fr_flags)
  );

  // loop state
  lfp_track #(.SAMPLE_BITS(SAMPLE_BITS)) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (fr_valid),
    .in_ready    (fr_ready),
    .err_i       (fr_err),
    .flags_i     (fr_flags),
    .out_valid   (tr_valid),
    .out_ready   (tr_ready),
    .err_o       (tr_err),
    .delta_o     (tr_delta),
    .sum_o       (tr_sum),
    .crossings_o (tr_cnt),
    .stat_o      (tr_stat)
  );

  // gain products
  lfp_mult #(.SAMPLE_BITS(SAMPLE_BITS)) u_mult (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (tr_valid),
    .in_ready      (tr_ready),
    .err_i         (tr_err),
    .delta_i       (tr_delta),
    .sum_i         (tr_sum),
    .crossings_i   (tr_cnt),
    .stat_i        (tr_stat),
    .p_gain        (p_gain_r),
    .i_gain_dt     (i_gain_dt_r),
    .d_gain_per_dt (d_gain_per_dt_r),
    .out_valid     (mu_valid),
    .out_ready     (mu_ready),
    .prod_p        (mu_p),
    .prod_d        (mu_d),
    .prod_i        (mu_i),
    .crossings_o   (mu_cnt),
    .stat_o        (mu_stat)
  );

  // control sum and wheel commands
  lfp_drive #(.SAMPLE_BITS(SAMPLE_BITS)) u_drive (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (mu_valid),
    .in_ready    (mu_ready),
    .prod_p      (mu_p),
    .prod_d      (mu_d),
    .prod_i      (mu_i),
    .crossings_i (mu_cnt),
    .stat_i      (mu_stat),
    .base_speed  (base_speed_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .right_drive (right_drive),
    .left_drive  (left_drive),
    .crossings_o (crossings),
    .stat_o      (out_stat)
  );

  // result packing
  assign out_tdata = {crossings, out_stat.line_edge, out_stat.on_line, left_drive, right_drive};

  // checks
  assign drive_sum = {right_drive[DRIVE_W-1], right_drive} +
                     {left_drive[DRIVE_W-1], left_drive};

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a free output always lets the whole pipe move
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is free");

  // an edge is only reported while on the line
  a_edge_on_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_stat.on_line || !out_stat.line_edge))
    else $error("line edge without line");

  // unsaturated wheel commands straddle the base speed
  a_drive_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && right_drive != DRIVE_HI && right_drive != DRIVE_LO &&
     left_drive != DRIVE_HI && left_drive != DRIVE_LO)
    |-> (drive_sum == {3'b000, base_speed_r, 1'b0}))
    else $error("wheel commands do not balance around base speed");

endmodule

[bench/tb_line_follow_pid_with_stopline_count.sv]
// ----------------------------------------------------------------------------
// tb_line_follow_pid_with_stopline_count
// Self-checking bench for the line-follow PID step with crossing-line counter.
// Sensor pairs go in through the input stream, and every result item is
// checked field by field against a software copy of the control loop. Gains,
// threshold and base speed are rewritten between phases while the pipeline is
// empty. Directed tests come first, then random phases, all but the last with
// idle bursts enabled on both streams.
// ----------------------------------------------------------------------------
module tb_line_follow_pid_with_stopline_count;
  import lfp_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 10;
  localparam int ERR_GAIN     = 254;
  localparam int ERR_SPAN     = 775;
  localparam int SAMPLE_MAX   = 1023;

  // addresses past the last register, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // one result item, laid out as on out_tdata
  typedef struct packed {
    logic [CNT_W-1:0]          crossings;
    logic                      line_edge;
    logic                      on_line;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
  } drive_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // mirrored registers, reset values
  logic signed [PGAIN_W-1:0] kp_mirror   = 16'sd320;
  logic signed [GAIN_W-1:0]  ki_mirror   = '0;
  logic signed [GAIN_W-1:0]  kd_mirror   = '0;
  logic [THR_W-1:0]          thr_mirror  = 10'd600;
  logic [BASE_W-1:0]         base_mirror = 8'd200;

  // mirrored loop state
  logic signed [FIELD_W-1:0] prev_err     = '0;
  logic signed [SUM_W-1:0]   err_total    = '0;
  logic                      seen_line    = 1'b0;
  logic [CNT_W-1:0]          cross_tally  = '0;

  drive_result_t drive_expect_q[$];
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  bit            src_idle_en    = 1'b0;
  bit            sink_idle_en   = 1'b0;
  int            stall_left     = 0;

  line_follow_pid_with_stopline_count u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one control step: clears, line detect, error scale, pid, clamps
  function automatic drive_result_t predict_drive(input logic [FIELD_W-1:0] rs,
                                                  input logic [FIELD_W-1:0] ls,
                                                  input logic clr_cnt,
                                                  input logic clr_err);
    drive_result_t res;
    longint        err_now;
    longint        acc;
    longint        ctrl;
    longint        rdrv;
    longint        ldrv;
    longint        total;
    if (clr_cnt) cross_tally = '0;
    if (clr_err) begin
      prev_err  = '0;
      err_total = '0;
    end
    res.on_line   = (rs >= thr_mirror) && (ls >= thr_mirror);
    res.line_edge = res.on_line && !seen_line;
    if (res.line_edge && cross_tally != CNT_MAX) cross_tally = cross_tally + 1'b1;

    // division of signed values truncates toward zero
    err_now = (longint'(ls) - longint'(rs)) * ERR_GAIN / ERR_SPAN;
    acc  = longint'(kp_mirror) * err_now * (longint'(1) << ALIGN_SHIFT);
    acc += longint'(ki_mirror) * longint'(err_total);
    acc += longint'(kd_mirror) * (err_now - longint'(prev_err))
           * (longint'(1) << ALIGN_SHIFT);
    ctrl = acc / (longint'(1) << CTRL_SHIFT);

    rdrv = longint'(base_mirror) + ctrl;
    ldrv = longint'(base_mirror) - ctrl;
    if (rdrv > longint'(DRIVE_HI)) rdrv = longint'(DRIVE_HI);
    if (rdrv < longint'(DRIVE_LO)) rdrv = longint'(DRIVE_LO);
    if (ldrv > longint'(DRIVE_HI)) ldrv = longint'(DRIVE_HI);
    if (ldrv < longint'(DRIVE_LO)) ldrv = longint'(DRIVE_LO);
    res.right_drive = rdrv[DRIVE_W-1:0];
    res.left_drive  = ldrv[DRIVE_W-1:0];
    res.crossings   = cross_tally;

    // history update, sum saturates at 32 bits
    seen_line = res.on_line;
    total = longint'(err_total) + err_now;
    if (total > longint'(SUM_MAX)) total = longint'(SUM_MAX);
    if (total < longint'(SUM_MIN)) total = longint'(SUM_MIN);
    err_total = total[SUM_W-1:0];
    prev_err  = err_now[FIELD_W-1:0];
    return res;
  endfunction

  // register write, enable left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] wdata);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    case (idx)
      REG_P_GAIN:         kp_mirror   = wdata[PGAIN_W-1:0];
      REG_I_GAIN_DT:      ki_mirror   = wdata;
      REG_D_GAIN_PER_DT:  kd_mirror   = wdata;
      REG_LINE_THRESHOLD: thr_mirror  = wdata[THR_W-1:0];
      REG_BASE_SPEED:     base_mirror = wdata[BASE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic signed [PGAIN_W-1:0] kp,
                                input logic signed [GAIN_W-1:0] ki,
                                input logic signed [GAIN_W-1:0] kd,
                                input logic [THR_W-1:0] thr,
                                input logic [BASE_W-1:0] base);
    write_reg(REG_P_GAIN, {{(CFG_DATA_W-PGAIN_W){kp[PGAIN_W-1]}}, kp});
    write_reg(REG_I_GAIN_DT, ki);
    write_reg(REG_D_GAIN_PER_DT, kd);
    write_reg(REG_LINE_THRESHOLD, {{(CFG_DATA_W-THR_W){1'b0}}, thr});
    write_reg(REG_BASE_SPEED, {{(CFG_DATA_W-BASE_W){1'b0}}, base});
    cfg_we <= 1'b0;
  endtask

  // send one sensor pair, optional idle burst first
  task automatic send_pair(input logic [FIELD_W-1:0] rs, input logic [FIELD_W-1:0] ls,
                           input logic clr_cnt, input logic clr_err);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, clr_err, clr_cnt, ls, rs};
    do @(posedge clk); while (!in_tready);
    drive_expect_q.push_back(predict_drive(rs, ls, clr_cnt, clr_err));
  endtask

  // stop sending and let every pending result come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (drive_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_pair();
    logic [FIELD_W-1:0] rs;
    logic [FIELD_W-1:0] ls;
    int                 lo;
    int                 hi;
    int                 pick;
    lo   = (thr_mirror > 8) ? thr_mirror - 8 : 0;
    hi   = (thr_mirror < SAMPLE_MAX - 8) ? thr_mirror + 8 : SAMPLE_MAX;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      rs = FIELD_W'($urandom_range(0, SAMPLE_MAX));
      ls = FIELD_W'($urandom_range(0, SAMPLE_MAX));
    end else if (pick < 8) begin
      // hover around the threshold so the line flag toggles often
      rs = FIELD_W'($urandom_range(lo, hi));
      ls = FIELD_W'($urandom_range(lo, hi));
    end else begin
      rs = FIELD_W'($urandom_range(thr_mirror, SAMPLE_MAX));
      ls = FIELD_W'($urandom_range(thr_mirror, SAMPLE_MAX));
    end
    send_pair(rs, ls, $urandom_range(0, 31) == 0, $urandom_range(0, 31) == 0);
  endtask

  // sink side: random stall bursts
  always @(posedge clk) begin
    if (sink_idle_en && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 5);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string fname, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      mismatch_count++;
      $error("%s mismatch: expected %0d, got %0d", fname, want_v, got_v);
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    drive_result_t want;
    drive_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (drive_expect_q.size() == 0) begin
        mismatch_count++;
        $error("result item with no pending sensor pair");
      end else begin
        want = drive_expect_q.pop_front();
        check_field("right_drive", want.right_drive, got.right_drive);
        check_field("left_drive", want.left_drive, got.left_drive);
        check_field("on_line", want.on_line, got.on_line);
        check_field("line_edge", want.line_edge, got.line_edge);
        check_field("crossings", want.crossings, got.crossings);
      end
    end
  end

  // reset register values, sample extremes and the threshold boundary
  task automatic test_reset_defaults();
    send_pair(10'd0, 10'd0, 1'b0, 1'b0);
    send_pair(10'd1023, 10'd1023, 1'b0, 1'b0);
    send_pair(10'd1023, 10'd1023, 1'b0, 1'b0);
    send_pair(10'd0, 10'd1023, 1'b0, 1'b0);
    send_pair(10'd1023, 10'd0, 1'b0, 1'b0);
    send_pair(10'd599, 10'd600, 1'b0, 1'b0);
    send_pair(10'd600, 10'd600, 1'b0, 1'b0);
    send_pair(10'd600, 10'd599, 1'b0, 1'b0);
    wait_drained();
  endtask

  // count and error-history clears, alone and together
  task automatic test_clear_flags();
    apply_settings(16'sd256, 32'sd1048576, 32'sd512, 10'd600, 8'd100);
    send_pair(10'd300, 10'd700, 1'b0, 1'b0);
    send_pair(10'd300, 10'd700, 1'b0, 1'b0);
    send_pair(10'd700, 10'd300, 1'b0, 1'b1);
    send_pair(10'd800, 10'd900, 1'b1, 1'b0);
    send_pair(10'd100, 10'd900, 1'b0, 1'b0);
    send_pair(10'd900, 10'd800, 1'b1, 1'b1);
    wait_drained();
  endtask

  // drive clamps at both gain extremes and both base extremes
  task automatic test_drive_saturation();
    apply_settings(16'sh7FFF, 32'sd0, 32'sd0, 10'd600, 8'd255);
    send_pair(10'd0, 10'd1023, 1'b0, 1'b1);
    send_pair(10'd1023, 10'd0, 1'b0, 1'b0);
    wait_drained();
    apply_settings(16'sh8000, 32'sd0, 32'sd0, 10'd600, 8'd0);
    send_pair(10'd0, 10'd1023, 1'b0, 1'b1);
    send_pair(10'd1023, 10'd0, 1'b0, 1'b0);
    wait_drained();
  endtask

  // threshold at zero and at full scale
  task automatic test_line_threshold_extremes();
    apply_settings(16'sd320, 32'sd0, 32'sd0, 10'd0, 8'd200);
    send_pair(10'd0, 10'd0, 1'b0, 1'b0);
    wait_drained();
    apply_settings(16'sd320, 32'sd0, 32'sd0, 10'd1023, 8'd200);
    send_pair(10'd1023, 10'd1022, 1'b0, 1'b0);
    send_pair(10'd1023, 10'd1023, 1'b0, 1'b0);
    wait_drained();
  endtask

  // writes to addresses past the register map change nothing
  task automatic test_spare_register_writes();
    apply_settings(16'sd512, 32'sd65536, 32'sd256, 10'd500, 8'd100);
    write_reg(REG_SPARE_5, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_6, 32'h8000_0155);
    write_reg(REG_SPARE_7, 32'h0000_8003);
    cfg_we <= 1'b0;
    send_pair(10'd200, 10'd900, 1'b0, 1'b0);
    send_pair(10'd900, 10'd200, 1'b0, 1'b0);
    send_pair(10'd600, 10'd600, 1'b0, 1'b0);
    wait_drained();
  endtask

  // repeated crossings count up back to back, then a clear on a crossing
  task automatic test_crossing_count();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    apply_settings(16'sd320, 32'sd0, 32'sd0, 10'd600, 8'd200);
    send_pair(10'd0, 10'd0, 1'b1, 1'b0);
    for (int n = 0; n < 10; n++) begin
      send_pair(10'd1023, 10'd1023, 1'b0, 1'b0);
      send_pair(10'd0, 10'd0, 1'b0, 1'b0);
    end
    send_pair(10'd1023, 10'd1023, 1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic run_random_phase(input int n_items, input bit pause_midway,
                                  input bit allow_idle);
    for (int k = 0; k < n_items; k++) begin
      if (k % 60 == 0) begin
        src_idle_en  = allow_idle && ($urandom_range(0, 3) != 0);
        sink_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
      end
      if (pause_midway && k == n_items / 2) wait_drained();
      send_random_pair();
    end
    wait_drained();
  endtask

  // random traffic across several register settings
  task automatic test_random_settings();
    apply_settings(16'sd320, 32'sd4000, 32'sd200, 10'd600, 8'd200);
    run_random_phase(305, 1'b0, 1'b1);
    apply_settings(16'sh8000, 32'sh8000_0000, 32'sh7FFF_FFFF, 10'd0, 8'd0);
    run_random_phase(305, 1'b0, 1'b1);
    apply_settings(16'sh7FFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 10'd1023, 8'd255);
    run_random_phase(305, 1'b1, 1'b1);
    for (int ph = 0; ph < 3; ph++) begin
      apply_settings(PGAIN_W'($urandom_range(0, 4000) - 2000),
                     GAIN_W'($urandom_range(0, 40000) - 20000),
                     GAIN_W'($urandom_range(0, 4000) - 2000),
                     THR_W'($urandom_range(0, SAMPLE_MAX)),
                     BASE_W'($urandom_range(0, 255)));
      run_random_phase(305, 1'b0, ph != 2);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_clear_flags();
    test_drive_saturation();
    test_line_threshold_extremes();
    test_spare_register_writes();
    test_crossing_count();
    test_random_settings();
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[line_follow_pid_with_stopline_count.f]
design/lfp_pkg.sv
design/lfp_front.sv
design/lfp_track.sv
design/lfp_mult.sv
design/lfp_drive.sv
design/line_follow_pid_with_stopline_count.sv
bench/tb_line_follow_pid_with_stopline_count.sv
